@@ hdl/upd_pkg.sv @@
// Shared types, constants and helper functions for the URL percent decoder.
`timescale 1ns / 1ps
`default_nettype none
package upd_pkg;

    localparam logic [7:0] PCT_CHAR = 8'h25;
    localparam logic [7:0] PRINT_LO = 8'h20;
    localparam logic [7:0] PRINT_HI = 8'h7E;
    localparam logic [3:0] HEX_ALPHA_BASE = 4'd10;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_PCT   = 2'd1;
    localparam logic [1:0] PH_DIGIT = 2'd2;

    localparam logic [1:0] MAX_CHARS = 2'd3;

    typedef struct packed {
        logic [7:0] in_char;
        logic       is_final;
    } item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       run_last;
    } result_t;

    // Up to three output characters produced by one request.
    typedef struct packed {
        logic [2:0][7:0] chars;
        logic [1:0]      cnt;
    } bundle_t;

    function automatic logic is_hex(input logic [7:0] c);
        is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46)
              || (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = c[3:0];
        end
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
        begin
            v = c[3:0] - 4'd1 + HEX_ALPHA_BASE;
        end
        hex_val = v;
    endfunction

    function automatic bundle_t add_char(input bundle_t b, input logic [7:0] c);
        bundle_t r;
        r = b;
        if (r.cnt != MAX_CHARS)
        begin
            r.chars[r.cnt] = c;
            r.cnt = r.cnt + 2'd1;
        end
        add_char = r;
    endfunction

endpackage
`default_nettype wire

@@ hdl/upd_front.sv @@
// Front end: accepts characters, tracks the escape phase and forms output bundles.
`timescale 1ns / 1ps
`default_nettype none
module upd_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire upd_pkg::item_t item,
    input  wire logic           q_full,
    output logic                full,
    output logic                wr_en,
    output upd_pkg::bundle_t    wr_data
);
    import upd_pkg::*;

    logic [1:0] phase_reg, phase_next;
    logic [7:0] held_reg, held_next;
    logic       accept;
    logic       take;
    logic [7:0] dec_byte;
    bundle_t    b;

    assign full   = q_full;
    assign accept = push && !q_full;

    always_comb
    begin
        b          = '0;
        phase_next = PH_IDLE;
        held_next  = held_reg;
        take       = 1'b0;
        dec_byte   = {hex_val(held_reg), hex_val(item.in_char)};
        priority if (phase_reg == PH_PCT)
        begin
            if (is_hex(item.in_char))
            begin
                phase_next = PH_DIGIT;
                held_next  = item.in_char;
            end
            else
            begin
                b    = add_char(b, PCT_CHAR);
                take = 1'b1;
            end
        end
        else if (phase_reg == PH_DIGIT)
        begin
            held_next = 8'd0;
            if (is_hex(item.in_char))
            begin
                if (dec_byte >= PRINT_LO && dec_byte <= PRINT_HI)
                begin
                    b = add_char(b, dec_byte);
                end
                else
                begin
                    b = add_char(b, PCT_CHAR);
                    b = add_char(b, held_reg);
                    b = add_char(b, item.in_char);
                end
            end
            else
            begin
                b    = add_char(b, PCT_CHAR);
                b    = add_char(b, held_reg);
                take = 1'b1;
            end
        end
        else
        begin
            take = 1'b1;
        end

        if (take)
        begin
            if (item.in_char == PCT_CHAR)
            begin
                phase_next = PH_PCT;
            end
            else
            begin
                b = add_char(b, item.in_char);
            end
        end

        if (item.is_final)
        begin
            if (phase_next == PH_PCT || phase_next == PH_DIGIT)
            begin
                b = add_char(b, PCT_CHAR);
            end
            if (phase_next == PH_DIGIT)
            begin
                b = add_char(b, held_next);
            end
            phase_next = PH_IDLE;
            held_next  = 8'd0;
        end
    end

    assign wr_en   = accept && (b.cnt != 2'd0);
    assign wr_data = b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            held_reg  <= 8'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

endmodule
`default_nettype wire

@@ hdl/upd_queue.sv @@
// Small bundle queue between the front end and the output serializer.
`timescale 1ns / 1ps
`default_nettype none
module upd_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire upd_pkg::bundle_t wr_data,
    input  wire logic             rd_en,
    output upd_pkg::bundle_t      rd_data,
    output logic                  q_full,
    output logic                  q_empty
);
    import upd_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    bundle_t       mem [DEPTH];
    logic [PW-1:0] wptr_reg, wptr_next;
    logic [PW-1:0] rptr_reg, rptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_wr, do_rd;

    assign q_full  = (cnt_reg == FULL_CNT);
    assign q_empty = (cnt_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = mem[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_wr)
        begin
            wptr_next = (wptr_reg == LAST_PTR) ? '0 : wptr_reg + PW'(1);
        end
        if (do_rd)
        begin
            rptr_next = (rptr_reg == LAST_PTR) ? '0 : rptr_reg + PW'(1);
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule
`default_nettype wire

@@ hdl/upd_back.sv @@
// Back end: hands out the characters of the oldest bundle one result at a time.
`timescale 1ns / 1ps
`default_nettype none
module upd_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire upd_pkg::bundle_t rd_data,
    input  wire logic             q_empty,
    input  wire logic             pop,
    output logic                  rd_en,
    output logic                  empty,
    output upd_pkg::result_t      result
);
    import upd_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       last;
    logic       fire;

    assign empty = q_empty;
    assign fire  = pop && !q_empty;
    assign last  = (idx_reg == rd_data.cnt - 2'd1);
    assign rd_en = fire && last;

    assign result.out_char = rd_data.chars[idx_reg];
    assign result.run_last = last;

    always_comb
    begin
        idx_next = idx_reg;
        if (fire)
        begin
            idx_next = last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 2'd0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule
`default_nettype wire

@@ hdl/url_percent_decoder.sv @@
// Top level of the streaming URL percent decoder.
// One path character is taken per request, and a character can be taken in every cycle
// while the internal bundle queue has room. Each request yields zero to three result
// characters; the output side gives one result per cycle while pop is high and the queue
// is not empty, so an escape that is passed through unchanged yields three results, and
// the queue of QUEUE_DEPTH bundles between the front end and the output serializer sets
// how long input keeps flowing while the output drains or stalls.
`timescale 1ns / 1ps
`default_nettype none
module url_percent_decoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    output logic                full,
    input  wire upd_pkg::item_t item,
    output logic                empty,
    input  wire logic           pop,
    output upd_pkg::result_t    result
);
    import upd_pkg::*;

    logic    wr_en, rd_en, q_full, q_empty;
    bundle_t wr_data, rd_data;

    upd_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .item    (item),
        .q_full  (q_full),
        .full    (full),
        .wr_en   (wr_en),
        .wr_data (wr_data)
    );

    upd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_data (rd_data),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    upd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_data (rd_data),
        .q_empty (q_empty),
        .pop     (pop),
        .rd_en   (rd_en),
        .empty   (empty),
        .result  (result)
    );

endmodule
`default_nettype wire

@@ dv/testbench.sv @@
// Self-checking testbench for the streaming URL percent decoder.
`timescale 1ns / 1ps
module testbench;
    import upd_pkg::*;

    class decode_scoreboard;
        result_t    expected_q[$];
        logic [7:0] emitted[$];
        logic [1:0] phase;
        logic [7:0] held_digit;
        int         mismatches;

        function new();
            phase = PH_IDLE;
            held_digit = 8'h00;
            mismatches = 0;
        endfunction

        function int nibble_of(logic [7:0] c);
            if (c >= "0" && c <= "9")
            begin
                return c - "0";
            end
            if (c >= "A" && c <= "F")
            begin
                return c - "A" + 10;
            end
            if (c >= "a" && c <= "f")
            begin
                return c - "a" + 10;
            end
            return -1;
        endfunction

        function void take_plain(logic [7:0] c);
            if (c == PCT_CHAR)
            begin
                phase = PH_PCT;
            end
            else
            begin
                emitted.push_back(c);
            end
        endfunction

        function void note_request(item_t req);
            int         lo;
            logic [7:0] decoded;
            result_t    r;
            emitted.delete();
            lo = nibble_of(req.in_char);
            if (phase == PH_PCT)
            begin
                if (lo >= 0)
                begin
                    phase = PH_DIGIT;
                    held_digit = req.in_char;
                end
                else
                begin
                    emitted.push_back(PCT_CHAR);
                    phase = PH_IDLE;
                    take_plain(req.in_char);
                end
            end
            else if (phase == PH_DIGIT)
            begin
                if (lo >= 0)
                begin
                    decoded = {4'(nibble_of(held_digit)), lo[3:0]};
                    if (decoded >= PRINT_LO && decoded <= PRINT_HI)
                    begin
                        emitted.push_back(decoded);
                    end
                    else
                    begin
                        emitted.push_back(PCT_CHAR);
                        emitted.push_back(held_digit);
                        emitted.push_back(req.in_char);
                    end
                    phase = PH_IDLE;
                    held_digit = 8'h00;
                end
                else
                begin
                    emitted.push_back(PCT_CHAR);
                    emitted.push_back(held_digit);
                    phase = PH_IDLE;
                    held_digit = 8'h00;
                    take_plain(req.in_char);
                end
            end
            else
            begin
                phase = PH_IDLE;
                take_plain(req.in_char);
            end
            if (req.is_final)
            begin
                if (phase == PH_PCT || phase == PH_DIGIT)
                begin
                    emitted.push_back(PCT_CHAR);
                end
                if (phase == PH_DIGIT)
                begin
                    emitted.push_back(held_digit);
                end
                phase = PH_IDLE;
                held_digit = 8'h00;
            end
            for (int i = 0; i < emitted.size(); i++)
            begin
                r.out_char = emitted[i];
                r.run_last = (i == emitted.size() - 1);
                expected_q.push_back(r);
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("Unexpected result: out_char=%h run_last=%b",
                             got.out_char, got.run_last);
                end
                return;
            end
            want = expected_q.pop_front();
            if (got.out_char !== want.out_char || got.run_last !== want.run_last)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display({"Mismatch: expected out_char=%h run_last=%b, ",
                              "got out_char=%h run_last=%b"},
                             want.out_char, want.run_last, got.out_char, got.run_last);
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    push = 1'b0;
    logic    pop = 1'b0;
    item_t   item = '0;
    logic    full;
    logic    empty;
    result_t result;

    decode_scoreboard sb = new();
    int gap_odds = 0;
    int stall_odds = 0;
    int stall_left = 0;

    url_percent_decoder u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .item(item),
        .empty(empty),
        .pop(pop),
        .result(result)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
            begin
                sb.note_request(item);
            end
            if (pop && !empty)
            begin
                sb.check_result(result);
            end
        end
    end

    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left = stall_left - 1;
        end
        else if (stall_odds != 0 && $urandom_range(0, stall_odds - 1) == 0)
        begin
            stall_left = $urandom_range(1, 8);
        end
        pop <= rst_n && (stall_left == 0);
    end

    task automatic send_char(input logic [7:0] c, input logic fin);
        item_t req;
        if (gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        req.in_char = c;
        req.is_final = fin;
        push <= 1'b1;
        item <= req;
        do @(posedge clk); while (full);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_char(s[i], i == s.len() - 1);
        end
    endtask

    initial
    begin
        logic [7:0] path[$];
        string      hex_chars;
        int         sent;
        int         kind;
        hex_chars = "0123456789abcdefABCDEF";
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text("%41");
        send_text("%2f");
        send_text("%7e");
        send_text("%7F");
        send_text("%4g");
        send_text("%%20");
        send_text("a%");
        send_text("%c");
        send_char(8'h01, 1'b0);
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b1);

        sent = 0;
        while (sent < 145)
        begin
            if (sent < 50)
            begin
                gap_odds = 3;
                stall_odds = 3;
            end
            else if (sent < 100)
            begin
                gap_odds = 10;
                stall_odds = 10;
            end
            else
            begin
                gap_odds = 0;
                stall_odds = 0;
            end
            path.delete();
            repeat ($urandom_range(1, 4))
            begin
                kind = $urandom_range(0, 9);
                if (kind < 5)
                begin
                    path.push_back(PCT_CHAR);
                    path.push_back(hex_chars[$urandom_range(0, 21)]);
                    path.push_back(hex_chars[$urandom_range(0, 21)]);
                end
                else if (kind < 6)
                begin
                    path.push_back(PCT_CHAR);
                    if ($urandom_range(0, 1))
                    begin
                        path.push_back(hex_chars[$urandom_range(0, 21)]);
                    end
                end
                else
                begin
                    path.push_back(8'($urandom_range(1, 255)));
                end
            end
            for (int i = 0; i < path.size(); i++)
            begin
                send_char(path[i], i == path.size() - 1);
            end
            sent += path.size();
        end
        push <= 1'b0;

        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (32) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial
    begin
        #500000;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule

@@ sim.f @@
hdl/upd_pkg.sv
hdl/upd_front.sv
hdl/upd_queue.sv
hdl/upd_back.sv
hdl/url_percent_decoder.sv
dv/testbench.sv
